FILE: src/m3i_pkg.sv
// Shared widths, types and cofactor index table for the 3x3 matrix inverse unit.
`timescale 1ns / 1ps
`default_nettype none
package m3i_pkg;

   // Element format: signed Q16.16
   localparam int ELEM_W     = 32;
   localparam int FRAC_W     = 16;
   localparam int NUM_ELEMS  = 9;

   // Exact intermediate widths
   localparam int PROD_W     = 2 * ELEM_W;             // element by element
   localparam int ADJ_W      = PROD_W + 1;             // difference of two products
   localparam int HALF_W     = ADJ_W - ELEM_W;         // upper part of a cofactor
   localparam int PART_W     = ELEM_W + HALF_W;        // partial product of the determinant
   localparam int DET_W      = ELEM_W + ADJ_W + 2;     // sum of three terms
   localparam int DMAG_W     = DET_W - 1;              // determinant magnitude
   localparam int NUM_W      = ADJ_W + 2 * FRAC_W;     // scaled cofactor magnitude
   localparam int QBITS      = ELEM_W;                 // quotient bits worked out
   localparam int DIV_W      = DMAG_W + QBITS;         // comparison width in the divider
   localparam int DIV_STAGES = QBITS;

   typedef logic [NUM_ELEMS-1:0][ELEM_W-1:0] m3i_mat_type;

   // Work handed from the front end to the divider
   typedef struct packed {
      logic [NUM_ELEMS-1:0][ADJ_W-1:0] amag;
      logic [NUM_ELEMS-1:0]            neg;
      logic [DMAG_W-1:0]               dmag;
      logic                            singular;
   } m3i_job_type;

   typedef struct packed {
      m3i_mat_type elem;
      logic        overflow;
      logic        singular;
   } m3i_result_type;

   // Element indices (row * 3 + column) of the two products of each cofactor
   typedef logic [3:0] m3i_idx_type;
   localparam m3i_idx_type COF_IDX [NUM_ELEMS][4] = '{
      '{4'd4, 4'd8, 4'd5, 4'd7},
      '{4'd2, 4'd7, 4'd1, 4'd8},
      '{4'd1, 4'd5, 4'd2, 4'd4},
      '{4'd5, 4'd6, 4'd3, 4'd8},
      '{4'd0, 4'd8, 4'd2, 4'd6},
      '{4'd2, 4'd3, 4'd0, 4'd5},
      '{4'd3, 4'd7, 4'd4, 4'd6},
      '{4'd1, 4'd6, 4'd0, 4'd7},
      '{4'd0, 4'd4, 4'd1, 4'd3}
   };

endpackage
`default_nettype wire

FILE: src/m3i_front.sv
// Front end: accepts matrices, forms cofactors and determinant, classifies signs.
`timescale 1ns / 1ps
`default_nettype none
module m3i_front import m3i_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire m3i_mat_type in_mat,
   output logic             job_valid,
   input  wire logic        job_ready,
   output m3i_job_type      job
);

   logic [7:1] vld_ff;
   logic       en;

   m3i_mat_type                s1_mat_ff;
   logic signed [PROD_W-1:0]   s2_pa_ff [NUM_ELEMS];
   logic signed [PROD_W-1:0]   s2_pb_ff [NUM_ELEMS];
   logic signed [ELEM_W-1:0]   s2_row_ff [3];
   logic signed [ADJ_W-1:0]    s3_adj_ff [NUM_ELEMS];
   logic signed [ELEM_W-1:0]   s3_row_ff [3];
   logic signed [PART_W-1:0]   s4_pl_ff [3];
   logic signed [PART_W-1:0]   s4_ph_ff [3];
   logic signed [ADJ_W-1:0]    s4_adj_ff [NUM_ELEMS];
   logic signed [DET_W-1:0]    s5_t_ff [3];
   logic signed [ADJ_W-1:0]    s5_adj_ff [NUM_ELEMS];
   logic signed [DET_W-1:0]    s6_det_ff;
   logic signed [ADJ_W-1:0]    s6_adj_ff [NUM_ELEMS];
   m3i_job_type                job_ff;
   m3i_job_type                job_in;

   // The whole front pipeline holds while its last stage waits on the queue
   assign en        = !vld_ff[7] || job_ready;
   assign in_ready  = en;
   assign job_valid = vld_ff[7];
   assign job       = job_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[6:1], in_valid};
      end
   end

   // Register the accepted transaction
   always_ff @(posedge clock) begin
      if (en) begin
         s1_mat_ff <= in_mat;
      end
   end

   // Two products per cofactor
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NUM_ELEMS; i++) begin
            s2_pa_ff[i] <= $signed(s1_mat_ff[COF_IDX[i][0]]) * $signed(s1_mat_ff[COF_IDX[i][1]]);
            s2_pb_ff[i] <= $signed(s1_mat_ff[COF_IDX[i][2]]) * $signed(s1_mat_ff[COF_IDX[i][3]]);
         end
         for (int j = 0; j < 3; j++) begin
            s2_row_ff[j] <= $signed(s1_mat_ff[j]);
         end
      end
   end

   // Adjugate elements
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NUM_ELEMS; i++) begin
            s3_adj_ff[i] <= ADJ_W'(s2_pa_ff[i]) - ADJ_W'(s2_pb_ff[i]);
         end
         s3_row_ff <= s2_row_ff;
      end
   end

   // First-row expansion: each cofactor is split into a low and a high part
   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 3; j++) begin
            s4_pl_ff[j] <= s3_row_ff[j] * $signed({1'b0, s3_adj_ff[3*j][ELEM_W-1:0]});
            s4_ph_ff[j] <= s3_row_ff[j] * $signed(s3_adj_ff[3*j][ADJ_W-1:ELEM_W]);
         end
         s4_adj_ff <= s3_adj_ff;
      end
   end

   // Recombine the partial products
   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 3; j++) begin
            s5_t_ff[j] <= (DET_W'(s4_ph_ff[j]) <<< ELEM_W) + DET_W'(s4_pl_ff[j]);
         end
         s5_adj_ff <= s4_adj_ff;
      end
   end

   // Determinant
   always_ff @(posedge clock) begin
      if (en) begin
         s6_det_ff <= s5_t_ff[0] + s5_t_ff[1] + s5_t_ff[2];
         s6_adj_ff <= s5_adj_ff;
      end
   end

   // Classify: magnitudes, result signs and the singular case
   always_comb begin
      logic [DET_W-1:0] dabs;
      logic [ADJ_W-1:0] aabs;
      dabs = s6_det_ff[DET_W-1] ? DET_W'(-s6_det_ff) : DET_W'(s6_det_ff);
      job_in.dmag     = dabs[DMAG_W-1:0];
      job_in.singular = (s6_det_ff == '0);
      for (int i = 0; i < NUM_ELEMS; i++) begin
         aabs = s6_adj_ff[i][ADJ_W-1] ? ADJ_W'(-s6_adj_ff[i]) : ADJ_W'(s6_adj_ff[i]);
         job_in.amag[i] = aabs;
         job_in.neg[i]  = s6_adj_ff[i][ADJ_W-1] ^ s6_det_ff[DET_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         job_ff <= job_in;
      end
   end

endmodule
`default_nettype wire

FILE: src/m3i_queue.sv
// Two-entry queue that decouples the front end from the divider.
`timescale 1ns / 1ps
`default_nettype none
module m3i_queue import m3i_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push_valid,
   output logic             push_ready,
   input  wire m3i_job_type push_job,
   output logic             pop_valid,
   input  wire logic        pop_ready,
   output m3i_job_type      pop_job
);

   m3i_job_type entry_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  count_ff;
   logic        push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_job    = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule
`default_nettype wire

FILE: src/m3i_divider.sv
// Back end: pipelined restoring division, rounding, saturation and output register.
`timescale 1ns / 1ps
`default_nettype none
module m3i_divider import m3i_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        job_valid,
   output logic             job_ready,
   input  wire m3i_job_type job,
   output logic             out_valid,
   input  wire logic        out_ready,
   output m3i_result_type   result
);

   logic                       en;
   logic [DIV_STAGES:0]        vld_ff;
   logic [NUM_W-1:0]           rem_ff  [DIV_STAGES+1][NUM_ELEMS];
   logic [QBITS-1:0]           quo_ff  [DIV_STAGES+1][NUM_ELEMS];
   logic [NUM_ELEMS-1:0]       pre_ff  [DIV_STAGES+1];
   logic [NUM_ELEMS-1:0]       neg_ff  [DIV_STAGES+1];
   logic [DMAG_W-1:0]          dmag_ff [DIV_STAGES+1];
   logic                       sing_ff [DIV_STAGES+1];
   logic                       out_vld_ff;
   m3i_result_type             res_ff;
   m3i_result_type             res_in;

   // Everything moves together when the output register is free or being taken
   assign en        = !out_vld_ff || out_ready;
   assign job_ready = en;
   assign out_valid = out_vld_ff;
   assign result    = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff     <= {vld_ff[DIV_STAGES-1:0], job_valid};
         out_vld_ff <= vld_ff[DIV_STAGES];
      end
   end

   // Entry stage: scale the numerators and flag quotients of 2^QBITS or more
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NUM_ELEMS; i++) begin
            rem_ff[0][i] <= {job.amag[i], {(2*FRAC_W){1'b0}}};
            quo_ff[0][i] <= '0;
            pre_ff[0][i] <= DIV_W'({job.amag[i], {(2*FRAC_W){1'b0}}})
                            >= {job.dmag, {QBITS{1'b0}}};
         end
         neg_ff[0]  <= job.neg;
         dmag_ff[0] <= job.dmag;
         sing_ff[0] <= job.singular;
      end
   end

   // One quotient bit per stage, most significant first
   for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_stage
      localparam int K = QBITS - s;
      logic [NUM_W-1:0] rem_in [NUM_ELEMS];
      logic [QBITS-1:0] quo_in [NUM_ELEMS];

      always_comb begin
         logic [DIV_W-1:0] shifted;
         logic [DIV_W:0]   diff;
         shifted = DIV_W'(dmag_ff[s-1]) << K;
         for (int i = 0; i < NUM_ELEMS; i++) begin
            diff      = {1'b0, DIV_W'(rem_ff[s-1][i])} - {1'b0, shifted};
            rem_in[i] = diff[DIV_W] ? rem_ff[s-1][i] : diff[NUM_W-1:0];
            quo_in[i] = quo_ff[s-1][i] | (QBITS'(!diff[DIV_W]) << K);
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_in;
            quo_ff[s]  <= quo_in;
            pre_ff[s]  <= pre_ff[s-1];
            neg_ff[s]  <= neg_ff[s-1];
            dmag_ff[s] <= dmag_ff[s-1];
            sing_ff[s] <= sing_ff[s-1];
         end
      end
   end

   // Round to nearest with ties away from zero, saturate and apply the sign
   always_comb begin
      logic             rnd;
      logic [QBITS:0]   qr;
      logic [QBITS:0]   lim;
      logic             ovf;
      logic [ELEM_W-1:0] mag;
      res_in.overflow = 1'b0;
      res_in.singular = sing_ff[DIV_STAGES];
      for (int i = 0; i < NUM_ELEMS; i++) begin
         rnd = DIV_W'({rem_ff[DIV_STAGES][i], 1'b0}) >= DIV_W'(dmag_ff[DIV_STAGES]);
         qr  = {1'b0, quo_ff[DIV_STAGES][i]} + (QBITS+1)'(rnd);
         lim = ((QBITS+1)'(1) << (ELEM_W-1)) - (QBITS+1)'(!neg_ff[DIV_STAGES][i]);
         ovf = pre_ff[DIV_STAGES][i] || (qr > lim);
         mag = ovf ? lim[ELEM_W-1:0] : qr[ELEM_W-1:0];
         if (sing_ff[DIV_STAGES]) begin
            res_in.elem[i] = '0;
         end else begin
            res_in.elem[i]  = neg_ff[DIV_STAGES][i] ? ELEM_W'(-mag) : mag;
            res_in.overflow = res_in.overflow | ovf;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

endmodule
`default_nettype wire

FILE: src/matrix3x3_inverse_unit.sv
// Top level of the 3x3 matrix inverse unit.
`timescale 1ns / 1ps
`default_nettype none
// Inverts one 3x3 matrix of signed Q16.16 elements per transaction by the
// adjugate method: the inverse elements are the cofactors divided by the
// determinant, rounded to nearest with ties away from zero. A zero
// determinant gives all-zero elements with the singular flag set; elements
// beyond the Q16.16 range saturate and set the overflow flag. A new matrix
// is taken every clock cycle unless back-pressure stalls the pipeline. An
// accepted input passes through the front end (input, products, cofactors,
// split determinant products, recombined terms, determinant and
// classification registers), the two-entry queue, and the divider, which has
// one pipeline stage per quotient bit plus an entry and an output stage.
module matrix3x3_inverse_unit import m3i_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_tvalid,
   output logic                req_tready,
   // in_r0c0, in_r0c1, in_r0c2, in_r1c0, ... in_r2c2, 32 bits each
   input  wire logic [287:0]   req_tdata,
   output logic                rsp_tvalid,
   input  wire logic           rsp_tready,
   // out_r0c0, out_r0c1, out_r0c2, out_r1c0, ... out_r2c2, 32 bits each
   output logic [287:0]        rsp_tdata,
   // singular, overflow
   output logic [1:0]          rsp_tuser
);

   logic           f_valid, f_ready, q_valid, q_ready;
   m3i_job_type    f_job, q_job;
   m3i_result_type res;

   m3i_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_mat    (req_tdata),
      .job_valid (f_valid),
      .job_ready (f_ready),
      .job       (f_job)
   );

   m3i_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_job   (f_job),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_job    (q_job)
   );

   m3i_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .job_valid (q_valid),
      .job_ready (q_ready),
      .job       (q_job),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .result    (res)
   );

   // Result transaction fields
   assign rsp_tdata = res.elem;
   assign rsp_tuser = {res.overflow, res.singular};

endmodule
`default_nettype wire
